FILE: hdl/atl_pkg.sv
package atl_pkg;

   localparam logic [2:0] TOK_EOF     = 3'd0;
   localparam logic [2:0] TOK_IDENT   = 3'd1;
   localparam logic [2:0] TOK_KEYWORD = 3'd2;
   localparam logic [2:0] TOK_INTEGER = 3'd3;
   localparam logic [2:0] TOK_CHAR    = 3'd4;

   localparam logic [2:0] CSR_KW_COUNT = 3'd0;
   localparam logic [2:0] CSR_KW_WORD0 = 3'd1;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UNDER = 8'h5f;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [19:0] LINE_MAX = 20'hfffff;
   localparam logic [15:0] COL_MAX  = 16'hffff;
   localparam logic [15:0] LEN_MAX  = 16'hffff;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_NAME = 2'd1,
      MODE_NUM  = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE       = 2'd0,
      ST_SEND_FLUSH = 2'd1,
      ST_SEND_CHAR  = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  char_code;
      logic [2:0]  keyword_number;
      logic [63:0] number_value;
      logic [15:0] token_length;
      logic [19:0] start_line;
      logic [15:0] start_column;
   } token_type;

   typedef struct packed {
      logic load;
      logic sel_char;
   } cmd_type;

   typedef struct packed {
      logic has_flush;
      logic has_char;
   } sts_type;

endpackage

FILE: hdl/atl_ctrl.sv
module atl_ctrl
   import atl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic    rsp_tlast,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           emit_pend_ff, emit_pend_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (sts.has_flush) begin
                  state_in = ST_SEND_FLUSH;
               end else if (sts.has_char) begin
                  state_in = ST_SEND_CHAR;
               end
            end
         end
         ST_SEND_FLUSH: begin
            if (rsp_tready) begin
               state_in = emit_pend_ff ? ST_SEND_CHAR : ST_IDLE;
            end
         end
         ST_SEND_CHAR: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      rsp_tlast    = 1'b0;
      cmd.load     = 1'b0;
      cmd.sel_char = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SEND_FLUSH: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = !emit_pend_ff;
         end
         ST_SEND_CHAR: begin
            rsp_tvalid   = 1'b1;
            rsp_tlast    = 1'b1;
            cmd.sel_char = 1'b1;
         end
         default: ;
      endcase
   end

   assign emit_pend_in = cmd.load ? sts.has_char : emit_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         emit_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         emit_pend_ff <= emit_pend_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_flush_first: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && sts.has_flush) |=> (rsp_tvalid && !cmd.sel_char))
      else $error("ended token not presented first");

   a_no_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !sts.has_flush && !sts.has_char) |=> req_tready)
      else $error("item without result left the block busy");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(cmd.sel_char)
                                       && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

FILE: hdl/atl_dp.sv
module atl_dp
   import atl_pkg::*;
#(
   parameter int KEYWORD_SLOTS = 7,
   parameter int KEYWORD_CHARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_kind,
   input  logic [7:0]  req_byte,
   input  cmd_type     cmd,
   output sts_type     sts,
   output token_type   rsp_tok
);

   localparam int NAME_W = 8 * KEYWORD_CHARS;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_head(input logic [7:0] c);
      is_head = (c == CHAR_UNDER) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   logic [2:0]        kw_count_ff;
   logic [NAME_W-1:0] kw_word_ff [KEYWORD_SLOTS];

   scan_mode_type     mode_ff, mode_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [15:0]       run_ff, run_in;
   logic [63:0]       acc_ff, acc_in;
   logic [19:0]       tok_line_ff, tok_line_in;
   logic [15:0]       tok_col_ff, tok_col_in;
   logic [19:0]       line_ff, line_in;
   logic [15:0]       col_ff, col_in;
   token_type         flush_tok_ff, flush_tok_in;
   token_type         char_tok_ff, char_tok_in;

   logic [7:0]        b;
   logic              in_name, in_num, cont_name, cont_num, cont;
   logic              start_head, start_digit, is_single, is_end;
   logic              kw_hit;
   logic [2:0]        kw_num;
   logic [NAME_W-1:0] name_grow;
   logic [15:0]       run_inc;
   logic [63:0]       acc_next;

   // keyword table
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_count_ff <= 3'd0;
      end else if (csr_we && csr_index == CSR_KW_COUNT) begin
         kw_count_ff <= csr_wdata[2:0];
      end
   end

   for (genvar i = 0; i < KEYWORD_SLOTS; i++) begin : g_kw
      always_ff @(posedge clock) begin
         if (reset) begin
            kw_word_ff[i] <= '0;
         end else if (csr_we && csr_index == CSR_KW_WORD0 + 3'(i)) begin
            kw_word_ff[i] <= csr_wdata[NAME_W-1:0];
         end
      end
   end

   always_comb begin
      kw_hit = 1'b0;
      kw_num = 3'd0;
      for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
         if (3'(i) < kw_count_ff && kw_word_ff[i] == name_ff) begin
            kw_hit = 1'b1;
            kw_num = 3'(i);
         end
      end
      if (run_ff > 16'(KEYWORD_CHARS)) begin
         kw_hit = 1'b0;
      end
   end

   // byte classes
   always_comb begin
      b = req_kind ? 8'd0 : req_byte;
      in_name = 1'b0;
      in_num  = 1'b0;
      unique case (mode_ff)
         MODE_NAME: in_name = 1'b1;
         MODE_NUM:  in_num  = 1'b1;
         default:   ;
      endcase
      cont_name   = in_name && (is_head(b) || is_digit(b));
      cont_num    = in_num && is_digit(b);
      cont        = cont_name || cont_num;
      is_end      = (b == 8'd0);
      start_head  = !cont && is_head(b);
      start_digit = !cont && is_digit(b);
      is_single   = !cont && !is_end && !is_space(b) && !is_head(b) && !is_digit(b);
      sts.has_flush = (in_name || in_num) && !cont;
      sts.has_char  = !cont && (is_end || is_single);
   end

   always_comb begin
      name_grow = name_ff;
      for (int j = 0; j < KEYWORD_CHARS; j++) begin
         if (run_ff == 16'(j)) begin
            name_grow[8*j +: 8] = b;
         end
      end
   end

   assign run_inc  = (run_ff < LEN_MAX) ? run_ff + 16'd1 : run_ff;
   assign acc_next = {acc_ff[60:0], 3'b000} + {acc_ff[62:0], 1'b0} + 64'(b - CHAR_ZERO);

   always_comb begin
      mode_in     = mode_ff;
      name_in     = name_ff;
      run_in      = run_ff;
      acc_in      = acc_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      if (cmd.load) begin
         if (cont) begin
            run_in = run_inc;
            if (cont_name) begin
               name_in = name_grow;
            end else begin
               acc_in = acc_next;
            end
         end else if (start_head || start_digit) begin
            mode_in     = start_head ? MODE_NAME : MODE_NUM;
            run_in      = 16'd1;
            tok_line_in = line_ff;
            tok_col_in  = col_ff;
            if (start_head) begin
               name_in = NAME_W'(b);
            end else begin
               acc_in = 64'(b - CHAR_ZERO);
            end
         end else begin
            mode_in = MODE_IDLE;
         end
         if (!is_end) begin
            if (b == CHAR_CR || b == CHAR_LF) begin
               col_in = 16'd1;
            end else if (col_ff < COL_MAX) begin
               col_in = col_ff + 16'd1;
            end
            if (b == CHAR_LF && line_ff < LINE_MAX) begin
               line_in = line_ff + 20'd1;
            end
         end
      end
   end

   always_comb begin
      flush_tok_in                = '0;
      flush_tok_in.token_length   = run_ff;
      flush_tok_in.start_line     = tok_line_ff;
      flush_tok_in.start_column   = tok_col_ff;
      if (in_num) begin
         flush_tok_in.kind         = TOK_INTEGER;
         flush_tok_in.number_value = acc_ff;
      end else if (kw_hit) begin
         flush_tok_in.kind           = TOK_KEYWORD;
         flush_tok_in.keyword_number = kw_num;
      end else begin
         flush_tok_in.kind = TOK_IDENT;
      end

      char_tok_in              = '0;
      char_tok_in.start_line   = line_ff;
      char_tok_in.start_column = col_ff;
      if (is_end) begin
         char_tok_in.kind = TOK_EOF;
      end else begin
         char_tok_in.kind         = TOK_CHAR;
         char_tok_in.char_code    = b;
         char_tok_in.token_length = 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         name_ff     <= '0;
         run_ff      <= 16'd0;
         acc_ff      <= 64'd0;
         tok_line_ff <= 20'd1;
         tok_col_ff  <= 16'd1;
         line_ff     <= 20'd1;
         col_ff      <= 16'd1;
      end else begin
         mode_ff     <= mode_in;
         name_ff     <= name_in;
         run_ff      <= run_in;
         acc_ff      <= acc_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         flush_tok_ff <= flush_tok_in;
         char_tok_ff  <= char_tok_in;
      end
   end

   assign rsp_tok = cmd.sel_char ? char_tok_ff : flush_tok_ff;

endmodule

FILE: hdl/assembler_token_lexer.sv
// channel | dir | handshake           | payload
// req     | in  | req_tvalid/tready   | tuser kind, tdata text_byte
// rsp     | out | rsp_tvalid/tready   | tuser token_kind, tdata token, tlast last_of_run
// csr     | in  | csr_we              | csr_index, csr_wdata
// an item that yields no token is only accepted; otherwise it is accepted and then
// each token is shown in turn, two tokens at most, set by the controller fsm
// keyword match and the x10 accumulate are done in the accept cycle
// reset is synchronous: position back to line 1 column 1, keyword table cleared
// req_tready stays low while a token waits on rsp_tready
module assembler_token_lexer
   import atl_pkg::*;
#(
   parameter int KEYWORD_SLOTS = 7,
   parameter int KEYWORD_CHARS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // text_byte
   input  logic         req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // char_code, keyword_number, number_value, token_length, start_line, start_column
   output logic [127:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // token_kind
   output logic         rsp_tlast
);

   cmd_type   cmd;
   sts_type   sts;
   token_type tok;

   atl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .sts        (sts),
      .cmd        (cmd)
   );

   atl_dp #(
      .KEYWORD_SLOTS (KEYWORD_SLOTS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_kind  (req_tuser),
      .req_byte  (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tok   (tok)
   );

   assign rsp_tuser = tok.kind;
   assign rsp_tdata = {1'b0, tok.start_column, tok.start_line, tok.token_length,
                       tok.number_value, tok.keyword_number, tok.char_code};

endmodule
